@@ src/cgsu_pkg.sv @@
// Shared types, constants and tables of the coupled Glauber spin update unit.
// No dependencies; the controller, datapath, top level and testbench import it.
package cgsu_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int NUM_W        = 11;
    localparam int VTX_W        = 10;
    localparam int WORD_W       = 32;
    localparam int STEP_W       = 48;
    localparam int SDATA_W      = 48;
    localparam int MDATA_W      = 88;
    localparam int PADDR_W      = 3;

    localparam logic [32:0]      ONE_Q32      = 33'h1_0000_0000;
    localparam logic [3:0]       TAYLOR_TERMS = 4'd14;
    localparam logic [ADDR_W-1:0] DIV_LAST_BIT = ADDR_W'(31);
    localparam logic [ADDR_W-1:0] SWEEP_LAST   = ADDR_W'(MAX_VERTICES - 1);
    localparam logic [NUM_W-1:0] N_MIN        = NUM_W'(2);
    localparam logic [NUM_W-1:0] N_MAX        = NUM_W'(MAX_VERTICES);

    localparam logic [NUM_W-1:0] RST_NUM_VERTICES = NUM_W'(1024);
    localparam logic [31:0]      RST_COUPLING     = 32'd16384;

    // register index, from paddr[2]
    localparam logic REG_NUM_VERTICES = 1'b0;
    localparam logic REG_COUPLING     = 1'b1;

    localparam logic OP_STEP    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_HSET, ST_H1, ST_H2, ST_H3, ST_ESQ, ST_IDLE, ST_RD, ST_SPIN,
        ST_MAG, ST_ESET, ST_KMUL, ST_DSET, ST_DIV, ST_PROB, ST_UPD, ST_DONE
    } t_state;

    typedef enum logic [4:0] {
        C_NOP, C_CLR, C_HSET, C_HMUL, C_HREC, C_HCOR, C_ESQ, C_LOAD, C_RD,
        C_SPIN, C_MAG, C_ESET, C_KMUL, C_DSET, C_DIV, C_PROB, C_UPD, C_OUT
    } t_cmd;

    typedef struct packed {
        t_cmd code;
        logic s_ready;
    } t_ctl;

    typedef struct packed {
        logic cnt_max;     // sweep at last entry
        logic cnt_one;     // last Horner term
        logic cnt_zero;    // last divider bit
        logic big;         // exponent argument >= 32, e = 0
        logic k_zero;      // no more exp(-1) factors
        logic in_bad;      // incoming vertex out of range
        logic in_restart;  // incoming item is a restart
        logic out_free;    // output register can load
        logic chain;       // 0 = upper chain, 1 = lower chain
    } t_sts;

    // floor(2^32 / j) for the Horner term divisors
    function automatic logic [32:0] recip(input logic [3:0] j);
        logic [32:0] m;
        case (j)
            4'd2:    m = 33'(ONE_Q32 / 2);
            4'd3:    m = 33'(ONE_Q32 / 3);
            4'd4:    m = 33'(ONE_Q32 / 4);
            4'd5:    m = 33'(ONE_Q32 / 5);
            4'd6:    m = 33'(ONE_Q32 / 6);
            4'd7:    m = 33'(ONE_Q32 / 7);
            4'd8:    m = 33'(ONE_Q32 / 8);
            4'd9:    m = 33'(ONE_Q32 / 9);
            4'd10:   m = 33'(ONE_Q32 / 10);
            4'd11:   m = 33'(ONE_Q32 / 11);
            4'd12:   m = 33'(ONE_Q32 / 12);
            4'd13:   m = 33'(ONE_Q32 / 13);
            4'd14:   m = 33'(ONE_Q32 / 14);
            default: m = ONE_Q32;
        endcase
        return m;
    endfunction

endpackage

@@ src/cgsu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cgsu_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/cgsu_ctrl.sv @@
// Controller state machine of the spin update unit.
// Depends on cgsu_pkg; drives cgsu_dp through t_ctl, reads t_sts.
module cgsu_ctrl import cgsu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_valid,
    input  t_sts i_sts,
    output t_ctl o_ctl
);
    t_state r_state, n_state;
    logic   r_init_done, n_init_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_init_done <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_done <= n_init_done;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_init_done = r_init_done;
        unique case (r_state)
            ST_CLEAR: if (i_sts.cnt_max) begin
                n_state = r_init_done ? ST_DONE : ST_HSET;
            end
            ST_HSET: n_state = ST_H1;
            ST_H1:   n_state = ST_H2;
            ST_H2:   n_state = ST_H3;
            ST_H3: if (i_sts.cnt_one) begin
                n_state = r_init_done ? ST_KMUL : ST_ESQ;
            end else begin
                n_state = ST_H1;
            end
            ST_ESQ: begin
                n_state     = ST_IDLE;
                n_init_done = 1'b1;
            end
            ST_IDLE: if (i_s_valid) begin
                priority if (i_sts.in_restart) n_state = ST_CLEAR;
                else if (i_sts.in_bad)         n_state = ST_DONE;
                else                           n_state = ST_RD;
            end
            ST_RD:   n_state = ST_SPIN;
            ST_SPIN: n_state = ST_MAG;
            ST_MAG:  n_state = ST_ESET;
            ST_ESET: n_state = i_sts.big ? ST_DSET : ST_H1;
            ST_KMUL: if (i_sts.k_zero) begin
                n_state = ST_DSET;
            end
            ST_DSET: n_state = ST_DIV;
            ST_DIV: if (i_sts.cnt_zero) begin
                n_state = ST_PROB;
            end
            ST_PROB: n_state = i_sts.chain ? ST_UPD : ST_MAG;
            ST_UPD:  n_state = ST_DONE;
            ST_DONE: if (i_sts.out_free) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_ctl.code    = C_NOP;
        o_ctl.s_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: o_ctl.code = C_CLR;
            ST_HSET:  o_ctl.code = C_HSET;
            ST_H1:    o_ctl.code = C_HMUL;
            ST_H2:    o_ctl.code = C_HREC;
            ST_H3:    o_ctl.code = C_HCOR;
            ST_ESQ:   o_ctl.code = C_ESQ;
            ST_IDLE: begin
                o_ctl.s_ready = 1'b1;
                if (i_s_valid) begin
                    o_ctl.code = C_LOAD;
                end
            end
            ST_RD:    o_ctl.code = C_RD;
            ST_SPIN:  o_ctl.code = C_SPIN;
            ST_MAG:   o_ctl.code = C_MAG;
            ST_ESET:  o_ctl.code = C_ESET;
            ST_KMUL:  o_ctl.code = C_KMUL;
            ST_DSET:  o_ctl.code = C_DSET;
            ST_DIV:   o_ctl.code = C_DIV;
            ST_PROB:  o_ctl.code = C_PROB;
            ST_UPD:   o_ctl.code = C_UPD;
            ST_DONE: if (i_sts.out_free) begin
                o_ctl.code = C_OUT;
            end
            default:  o_ctl.code = C_NOP;
        endcase
    end
endmodule

@@ src/cgsu_dp.sv @@
// Datapath: spin store, counts, Horner exp unit, exp(-1) multiplier loop,
// restoring divider and output register. Depends on cgsu_pkg and cgsu_ram.
module cgsu_dp import cgsu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctl               i_ctl,
    output t_sts               o_sts,
    input  logic [NUM_W-1:0]   i_n,
    input  logic [31:0]        i_coupling,
    input  logic [SDATA_W-1:0] i_s_data,
    input  logic               i_s_op,
    input  logic               i_m_ready,
    output logic               o_m_valid,
    output logic [MDATA_W-1:0] o_m_data,
    output logic               o_m_bad
);
    logic [ADDR_W-1:0] r_cnt;
    logic [VTX_W-1:0]  r_vertex;
    logic [WORD_W-1:0] r_rword;
    logic              r_bad, r_chain, r_u, r_l, r_nu, r_nl, r_neg;
    logic [NUM_W-1:0]  r_upper_plus, r_lower_plus, r_dis;
    logic [STEP_W-1:0] r_steps;
    logic [44:0]       r_a;
    logic [4:0]        r_k;
    logic [31:0]       r_f, r_x, r_einv, r_q;
    logic [32:0]       r_t, r_rem;
    logic [33:0]       r_div;
    logic [63:0]       r_prod;
    logic [64:0]       r_y;
    logic              r_out_valid, r_out_bad;
    logic [MDATA_W-1:0] r_out_data;

    logic [1:0]        w_rdata, w_wdata;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;

    cgsu_ram #(.WIDTH(2), .DEPTH(MAX_VERTICES)) u_spins (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_ctl.code == C_RD),
        .i_raddr (ADDR_W'(r_vertex)),
        .o_rdata (w_rdata)
    );

    // store word: bit 1 upper chain, bit 0 lower chain
    assign w_we    = (i_ctl.code == C_CLR) || (i_ctl.code == C_UPD);
    assign w_waddr = (i_ctl.code == C_CLR) ? r_cnt : ADDR_W'(r_vertex);
    assign w_wdata = (i_ctl.code == C_CLR) ? {(NUM_W'(r_cnt) < i_n), 1'b0} : {r_nu, r_nl};

    // local field of the selected chain
    logic [NUM_W-1:0]  w_plus;
    logic              w_spin;
    logic signed [12:0] w_s;
    logic [11:0]       w_mag;
    logic [44:0]       w_cm;
    assign w_plus = r_chain ? r_lower_plus : r_upper_plus;
    assign w_spin = r_chain ? r_l : r_u;
    assign w_s    = $signed({1'b0, w_plus, 1'b0}) - $signed({2'b0, i_n})
                  + (w_spin ? -13'sd1 : 13'sd1);
    assign w_mag  = w_s[12] ? 12'(-w_s) : 12'(w_s);
    assign w_cm   = 45'(i_coupling) * 45'(w_mag);

    // Horner term: t = 1 - floor(floor(f*t) / j), reciprocal plus one correction
    logic [64:0] w_ft, w_xm, w_km;
    logic [65:0] w_sq;
    logic [32:0] w_q0, w_q;
    logic [36:0] w_qj, w_r;
    assign w_ft = 65'(r_f) * 65'(r_t);
    assign w_xm = 65'(r_prod[63:32]) * 65'(recip(r_cnt[3:0]));
    assign w_q0 = r_y[64:32];
    assign w_qj = 37'(w_q0) * 37'(r_cnt[3:0]);
    assign w_r  = 37'(r_x) - w_qj;
    assign w_q  = (w_r >= 37'(r_cnt[3:0])) ? w_q0 + 33'd1 : w_q0;
    assign w_sq = 66'(r_t) * 66'(r_t);
    assign w_km = 65'(r_t) * 65'(r_einv);

    // divider step
    logic [33:0] w_rem2;
    logic        w_ge;
    assign w_rem2 = {r_rem, 1'b1};
    assign w_ge   = (w_rem2 >= r_div);

    logic        w_azero;
    logic [31:0] w_p;
    logic        w_bit;
    assign w_azero = (r_a == '0);
    assign w_p     = (r_neg && !w_azero) ? ~r_q : r_q;
    assign w_bit   = (r_rword <= w_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_chain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_ctl.code)
                C_CLR: begin
                    if (r_cnt == SWEEP_LAST) begin
                        r_cnt        <= '0;
                        r_upper_plus <= i_n;
                        r_lower_plus <= '0;
                        r_dis        <= i_n;
                        r_steps      <= '0;
                        r_bad        <= 1'b0;
                    end else begin
                        r_cnt <= r_cnt + ADDR_W'(1);
                    end
                end
                C_HSET: begin
                    r_f   <= 32'h8000_0000;
                    r_t   <= ONE_Q32;
                    r_cnt <= ADDR_W'(TAYLOR_TERMS);
                end
                C_HMUL: r_prod <= w_ft[63:0];
                C_HREC: begin
                    r_x <= r_prod[63:32];
                    r_y <= w_xm;
                end
                C_HCOR: begin
                    r_t   <= ONE_Q32 - w_q;
                    r_cnt <= r_cnt - ADDR_W'(1);
                end
                C_ESQ: r_einv <= w_sq[63:32];
                C_LOAD: begin
                    r_vertex <= i_s_data[VTX_W-1:0];
                    r_rword  <= i_s_data[VTX_W +: WORD_W];
                    r_bad    <= o_sts.in_bad;
                    r_chain  <= 1'b0;
                    r_cnt    <= '0;
                end
                C_RD: ;
                C_SPIN: begin
                    r_u <= w_rdata[1];
                    r_l <= w_rdata[0];
                end
                C_MAG: begin
                    r_a   <= {w_cm[43:0], 1'b0};
                    r_neg <= w_s[12];
                end
                C_ESET: begin
                    r_f   <= {r_a[23:0], 8'd0};
                    r_t   <= o_sts.big ? 33'd0 : ONE_Q32;
                    r_k   <= o_sts.big ? 5'd0 : r_a[28:24];
                    r_cnt <= ADDR_W'(TAYLOR_TERMS);
                end
                C_KMUL: if (r_k != 5'd0) begin
                    r_t <= w_km[64:32];
                    r_k <= r_k - 5'd1;
                end
                C_DSET: begin
                    r_rem <= 33'h0_FFFF_FFFF;
                    r_div <= {1'b0, ONE_Q32} + {1'b0, r_t};
                    r_q   <= '0;
                    r_cnt <= DIV_LAST_BIT;
                end
                C_DIV: begin
                    r_rem <= w_ge ? 33'(w_rem2 - r_div) : w_rem2[32:0];
                    r_q   <= {r_q[30:0], w_ge};
                    r_cnt <= r_cnt - ADDR_W'(1);
                end
                C_PROB: begin
                    if (r_chain) r_nl <= w_bit;
                    else         r_nu <= w_bit;
                    r_chain <= ~r_chain;
                end
                C_UPD: begin
                    if (r_nu && !r_u) r_upper_plus <= r_upper_plus + NUM_W'(1);
                    if (!r_nu && r_u) r_upper_plus <= r_upper_plus - NUM_W'(1);
                    if (r_nl && !r_l) r_lower_plus <= r_lower_plus + NUM_W'(1);
                    if (!r_nl && r_l) r_lower_plus <= r_lower_plus - NUM_W'(1);
                    if (r_u == r_l && r_nu != r_nl)      r_dis <= r_dis + NUM_W'(1);
                    else if (r_u != r_l && r_nu == r_nl) r_dis <= r_dis - NUM_W'(1);
                    r_steps <= r_steps + STEP_W'(1);
                end
                C_OUT: begin
                    r_out_data <= {6'd0, (r_upper_plus == r_lower_plus), r_dis,
                                   r_lower_plus, r_upper_plus, r_steps};
                    r_out_bad  <= r_bad;
                end
                default: ;
            endcase
            if (i_ctl.code == C_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.cnt_max    = (r_cnt == SWEEP_LAST);
    assign o_sts.cnt_one    = (r_cnt == ADDR_W'(1));
    assign o_sts.cnt_zero   = (r_cnt == '0);
    assign o_sts.big        = |r_a[44:29];
    assign o_sts.k_zero     = (r_k == 5'd0);
    assign o_sts.in_bad     = (i_s_op == OP_STEP) && ({1'b0, i_s_data[VTX_W-1:0]} >= i_n);
    assign o_sts.in_restart = (i_s_op == OP_RESTART);
    assign o_sts.out_free   = !r_out_valid || i_m_ready;
    assign o_sts.chain      = r_chain;

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;
    assign o_m_bad   = r_out_bad;
endmodule

@@ src/coupled_glauber_spin_update_unit.sv @@
// Top level of the coupled Glauber spin update unit: APB registers,
// controller and datapath. Depends on cgsu_pkg, cgsu_ctrl, cgsu_dp, cgsu_ram.
//
//  channel   dir  handshake             payload
//  s_*       in   s_tvalid / s_tready   tdata: vertex, random_word; tuser: op
//  m_*       out  m_tvalid / m_tready   tdata: counts, coupled; tuser: bad_vertex
//  APB       in   psel, penable, pwrite num_vertices @0x0, coupling @0x4
//
// Work: a restart item runs one sweep through the spin store between accept and
// output. An out-of-range vertex goes straight from accept to output. An update
// step runs, once per chain on one shared unit, a 14-term Horner exp (multiply,
// reciprocal multiply and correction per term), then one multiply per exp(-1)
// factor, k of them with k = integer part of the chain's exp argument (0..31),
// then a 32-bit restoring divider. When the argument reaches 32 the exp is zero
// and the Horner and multiply steps are skipped.
// Reset: a clearing pass over all MAX_VERTICES entries loads the spin store, then
// the exp(-1) constant is built; no item is taken until then.
// Stalls: the output register holds one finished item; the next item is taken
// while it waits, and a second result waits in the controller.
module coupled_glauber_spin_update_unit import cgsu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // slave side
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [SDATA_W-1:0] s_tdata,   // [9:0] vertex, [41:10] random_word, zero pad
    input  logic               s_tuser,   // [0] op
    // master side
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MDATA_W-1:0] m_tdata,   // [47:0] step_count, [58:48] upper_plus_count,
                                          // [69:59] lower_plus_count,
                                          // [80:70] disagree_count, [81] coupled, pad
    output logic               m_tuser,   // [0] bad_vertex
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    logic [NUM_W-1:0] r_num_vertices;
    logic [31:0]      r_coupling;
    logic [NUM_W-1:0] w_n;
    logic             w_wr;
    t_ctl             w_ctl;
    t_sts             w_sts;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vertices <= RST_NUM_VERTICES;
            r_coupling     <= RST_COUPLING;
        end else if (w_wr) begin
            if (paddr[2] == REG_NUM_VERTICES) r_num_vertices <= pwdata[NUM_W-1:0];
            else                              r_coupling     <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_COUPLING) ? r_coupling : 32'(r_num_vertices);

    // vertex count in use, clamped to [2, MAX_VERTICES]
    always_comb begin
        priority if (r_num_vertices < N_MIN) w_n = N_MIN;
        else if (r_num_vertices > N_MAX)     w_n = N_MAX;
        else                                 w_n = r_num_vertices;
    end

    cgsu_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .i_sts     (w_sts),
        .o_ctl     (w_ctl)
    );

    cgsu_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .o_sts      (w_sts),
        .i_n        (w_n),
        .i_coupling (r_coupling),
        .i_s_data   (s_tdata),
        .i_s_op     (s_tuser),
        .i_m_ready  (m_tready),
        .o_m_valid  (m_tvalid),
        .o_m_data   (m_tdata),
        .o_m_bad    (m_tuser)
    );

    assign s_tready = w_ctl.s_ready;

    // plus counts can differ by no more than the disagreement count
    logic [NUM_W-1:0] w_up, w_lo, w_gap;
    assign w_up  = m_tdata[58:48];
    assign w_lo  = m_tdata[69:59];
    assign w_gap = (w_up >= w_lo) ? (w_up - w_lo) : (w_lo - w_up);

    a_gap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (w_gap <= m_tdata[80:70]))
        else $error("plus count gap exceeds disagreement count");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in work");

    a_bad_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[81] == (w_up == w_lo)))
        else $error("coupled flag inconsistent on rejected vertex");
endmodule

@@ tb/testbench.sv @@
// Testbench of the coupled Glauber spin update unit: drives step and restart items,
// predicts both chains and checks every result. Depends on cgsu_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
    import cgsu_pkg::*;

    localparam int WATCH_LIMIT = 20000;   // idle cycles: clearing pass plus stalled steps

    typedef struct {
        logic [STEP_W-1:0] steps;
        logic [NUM_W-1:0]  upper;
        logic [NUM_W-1:0]  lower;
        logic [NUM_W-1:0]  disagree;
        logic              coupled;
        logic              bad;
    } t_tally;

    // Predictor of both chains plus the queue of expected tallies
    class chain_scoreboard;
        bit                upper_spin[MAX_VERTICES];
        bit                lower_spin[MAX_VERTICES];
        int unsigned       upper_plus, lower_plus, disagree;
        logic [STEP_W-1:0] steps;
        logic [NUM_W-1:0]  nv_reg;
        logic [31:0]       cpl_reg;
        longint unsigned   e_inv;
        t_tally            pending[$];
        int                errors;

        function new();
            longint unsigned h;
            nv_reg  = RST_NUM_VERTICES;
            cpl_reg = RST_COUPLING;
            h       = exp_frac(64'h8000_0000);
            e_inv   = (h * h) >> 32;
            errors  = 0;
            restart();
        endfunction

        function int unsigned n_eff();
            if (nv_reg < N_MIN) return N_MIN;
            if (nv_reg > N_MAX) return N_MAX;
            return nv_reg;
        endfunction

        function void restart();
            int unsigned n;
            n = n_eff();
            for (int i = 0; i < MAX_VERTICES; i++) begin
                upper_spin[i] = (i < n);
                lower_spin[i] = 1'b0;
            end
            upper_plus = n;
            lower_plus = 0;
            disagree   = n;
            steps      = '0;
        endfunction

        function void set_reg(logic idx, logic [31:0] val);
            if (idx == REG_NUM_VERTICES) nv_reg = val[NUM_W-1:0];
            else cpl_reg = val;
        endfunction

        // Truncating Horner series of exp(-f), f in Q0.32
        function longint unsigned exp_frac(longint unsigned f);
            longint unsigned t;
            t = 64'h1_0000_0000;
            for (int j = TAYLOR_TERMS; j >= 1; j--)
                t = 64'h1_0000_0000 - ((f * t) >> 32) / j;
            return t;
        endfunction

        // Logistic probability of a plus spin, Q0.32
        function longint unsigned plus_prob(int unsigned plus, bit spin, int unsigned n);
            longint          s;
            longint unsigned mag, arg, e, p;
            s   = 2 * longint'(plus) - longint'(n) - (spin ? 1 : -1);
            mag = (s < 0) ? -s : s;
            arg = 2 * longint'(cpl_reg) * mag;
            if (arg >= (64'd32 << 24)) begin
                e = 0;
            end else begin
                e = exp_frac((arg & 64'hFF_FFFF) << 8);
                for (int k = 0; k < (arg >> 24); k++)
                    e = (e * e_inv) >> 32;
            end
            p = 64'hFFFF_FFFF_FFFF_FFFF / (64'h1_0000_0000 + e);
            if (s < 0 && arg != 0) p = 64'hFFFF_FFFF - p;
            return p;
        endfunction

        function void note_item(logic op, logic [VTX_W-1:0] v, logic [WORD_W-1:0] rw);
            t_tally      x;
            int unsigned n;
            bit          u, l, nu, nl;
            x.bad = 1'b0;
            n     = n_eff();
            if (op == OP_RESTART) begin
                restart();
            end else if (v >= n) begin
                x.bad = 1'b1;
            end else begin
                u  = upper_spin[v];
                l  = lower_spin[v];
                nu = (rw <= plus_prob(upper_plus, u, n));
                nl = (rw <= plus_prob(lower_plus, l, n));
                if (nu && !u) upper_plus++;
                if (!nu && u) upper_plus--;
                if (nl && !l) lower_plus++;
                if (!nl && l) lower_plus--;
                if (u == l && nu != nl) disagree++;
                else if (u != l && nu == nl) disagree--;
                upper_spin[v] = nu;
                lower_spin[v] = nl;
                steps++;
            end
            x.steps    = steps;
            x.upper    = upper_plus[NUM_W-1:0];
            x.lower    = lower_plus[NUM_W-1:0];
            x.disagree = disagree[NUM_W-1:0];
            x.coupled  = (upper_plus == lower_plus);
            pending.push_back(x);
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
            errors++;
        endtask

        task check_result(logic [MDATA_W-1:0] d, logic bad);
            t_tally x;
            if (pending.size() == 0) begin
                report("unexpected item", 1, 0);
                return;
            end
            x = pending.pop_front();
            if (d[47:0] !== x.steps)     report("step_count", d[47:0], x.steps);
            if (d[58:48] !== x.upper)    report("upper_plus_count", d[58:48], x.upper);
            if (d[69:59] !== x.lower)    report("lower_plus_count", d[69:59], x.lower);
            if (d[80:70] !== x.disagree) report("disagree_count", d[80:70], x.disagree);
            if (d[81] !== x.coupled)     report("coupled", d[81], x.coupled);
            if (bad !== x.bad)           report("bad_vertex", bad, x.bad);
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [SDATA_W-1:0] s_tdata = '0;    // [9:0] vertex, [41:10] random_word
    logic               s_tuser = 1'b0;  // [0] op
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [MDATA_W-1:0] m_tdata;         // [47:0] steps, [58:48] upper, [69:59] lower,
                                         // [80:70] disagree, [81] coupled
    logic               m_tuser;         // [0] bad_vertex
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    chain_scoreboard sb = new();
    bit              calm = 1'b0;        // no idling on either side while set
    int              quiet_cycles = 0;

    coupled_glauber_spin_update_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Result side: random backpressure, checking, and the no-progress watchdog
    always @(posedge i_clk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 13);
        if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCH_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Two-phase register write; the register takes the value at the access edge
    task apb_write(logic idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Drop the input, wait for every outstanding result, then let the unit settle
    task drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task configure(logic [31:0] nv, logic [31:0] cpl);
        drain();
        apb_write(REG_NUM_VERTICES, nv);
        apb_write(REG_COUPLING, cpl);
    endtask

    // Present one item; may idle first so gaps land on any phase of the work
    task send_item(logic op, logic [VTX_W-1:0] v, logic [WORD_W-1:0] rw);
        if (!calm && $urandom_range(0, 99) < 13) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= SDATA_W'({rw, v});
        do @(posedge i_clk); while (!s_tready);
        sb.note_item(op, v, rw);
    endtask

    task random_items(int count);
        int unsigned   n, pick;
        logic [31:0]   rw;
        for (int i = 0; i < count; i++) begin
            n    = sb.n_eff();
            pick = $urandom_range(0, 99);
            rw   = $urandom();
            if ($urandom_range(0, 19) == 0) rw = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            if (pick < 2)
                send_item(OP_RESTART, VTX_W'($urandom()), rw);
            else if (pick < 8)
                send_item(OP_STEP, VTX_W'($urandom_range(0, MAX_VERTICES - 1)), rw);
            else
                send_item(OP_STEP, VTX_W'($urandom_range(0, n - 1)), rw);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, extreme words and vertices, a restart
        send_item(OP_STEP, 10'd0, 32'h0);
        send_item(OP_STEP, 10'd1023, 32'hFFFF_FFFF);
        send_item(OP_RESTART, 10'h3FF, 32'hFFFF_FFFF);
        send_item(OP_STEP, 10'd512, 32'h8000_0000);
        // smallest graph, zero coupling: out-of-range vertices flagged
        configure(2, 0);
        send_item(OP_RESTART, 10'd0, 32'h0);
        send_item(OP_STEP, 10'd0, 32'h8000_0000);
        send_item(OP_STEP, 10'd1, 32'h7FFF_FFFF);
        send_item(OP_STEP, 10'd2, 32'h0);
        send_item(OP_STEP, 10'd1023, 32'h1234_5678);
        // register below range clamps to two; count change without restart
        configure(0, 32'hFFFF_FFFF);
        send_item(OP_STEP, 10'd1, 32'h0);
        send_item(OP_STEP, 10'd0, 32'hFFFF_FFFF);
        configure(1, 32'h0100_0000);
        send_item(OP_STEP, 10'd2, 32'h0);
        // register above range clamps to the maximum; grown graph keeps old spins
        configure(11'h7FF, 32'hFFFF_FFFF);
        send_item(OP_STEP, 10'd700, 32'h0);
        send_item(OP_STEP, 10'd1023, 32'hFFFF_FFFF);
        send_item(OP_RESTART, 10'd5, 32'h5);
        send_item(OP_STEP, 10'd1023, 32'h0);
        send_item(OP_STEP, 10'd0, 32'hFFFF_FFFF);

        // random phases across several settings
        configure(8, 32'h0100_0000);   send_item(OP_RESTART, 0, 0); random_items(300);
        configure(1024, 16384);        send_item(OP_RESTART, 0, 0); random_items(300);
        calm = 1'b1;
        configure(64, 32'h0040_0000);  send_item(OP_RESTART, 0, 0); random_items(300);
        calm = 1'b0;
        configure(3, 32'h0800_0000);   send_item(OP_RESTART, 0, 0); random_items(300);
        configure(100, 32'h0010_0000); random_items(300);
        configure(2, 0);               send_item(OP_RESTART, 0, 0); random_items(150);
        configure(1000, 32'hFFFF_FFFF); random_items(150);
        configure(1024, $urandom());   send_item(OP_RESTART, 0, 0); random_items(200);

        drain();
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
